@@ rtl/pt2d_pkg.sv @@
package pt2d_pkg;

   // Default geometry of the datapath.
   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int TRIG_FRACTION_BITS_DEFAULT = 15;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_ADDR_W-1:0] REG_MODE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SHIFT_X = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SHIFT_Y = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGLE   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_X = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_Y = 3'd5;

   // Transform modes.
   localparam logic [2:0] MODE_TRANSLATE = 3'd0;
   localparam logic [2:0] MODE_ROTATE    = 3'd1;
   localparam logic [2:0] MODE_SCALE     = 3'd2;
   localparam logic [2:0] MODE_REFLECT_Y = 3'd3;
   localparam logic [2:0] MODE_REFLECT_X = 3'd4;

   // Screen center of the geometric frame.
   localparam int CENTER_X = 320;
   localparam int CENTER_Y = 240;

   // Decoupling queue between classification and arithmetic.
   localparam int QUEUE_DEPTH = 4;

   // Angle table: 512 entries so every 9-bit angle code has a value.
   localparam int ANGLE_CODES = 512;
   localparam int TRIG_ENTRY_W = 32;
   localparam int SERIES_BITS = 33;
   localparam int SERIES_TERMS = 60;
   localparam longint unsigned ANGLE_STEP = 1744;
   localparam longint unsigned ANGLE_SCALE = 100000;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [12:0] shift_x;
      logic signed [12:0] shift_y;
      logic signed [6:0]  scale_x;
      logic signed [6:0]  scale_y;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Sine or cosine of angle code d times 0.01744 rad, from the Maclaurin series in
   // unsigned Q33 with truncating steps, then rounded half away from zero to frac_bits
   // fraction bits. Called with constant arguments only.
   function automatic logic signed [TRIG_ENTRY_W-1:0] trig_entry(input int d,
                                                                  input int frac_bits,
                                                                  input bit want_sine);
      logic [63:0]      a;
      logic [63:0]      t;
      logic [63:0]      s;
      logic [63:0]      c;
      logic [63:0]      v;
      logic [63:0]      mag;
      int               sh;
      a = 64'(d) * ANGLE_STEP;
      t = 64'd1 << SERIES_BITS;
      s = 64'd0;
      c = t;
      for (int m = 1; m <= SERIES_TERMS; m++) begin
         t = (t * a) / ANGLE_SCALE;
         t = t / 64'(m);
         unique case (m & 3)
            1: s = s + t;
            2: c = c - t;
            3: s = s - t;
            default: c = c + t;
         endcase
      end
      v = want_sine ? s : c;
      sh = SERIES_BITS - frac_bits;
      mag = v[63] ? (64'd0 - v) : v;
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      v = v[63] ? (64'd0 - mag) : mag;
      return v[TRIG_ENTRY_W-1:0];
   endfunction

endpackage

@@ rtl/pt2d_queue.sv @@
module pt2d_queue
   import pt2d_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

@@ rtl/pt2d_front.sv @@
module pt2d_front
   import pt2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEFAULT,
   localparam int AW = COORD_WIDTH + 2,
   localparam int BW = TRIG_FRACTION_BITS + 2,
   localparam int ENTRY_W = 1 + 4 * AW + 4 * BW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_WIDTH-1:0] x_in,
   input  logic signed [COORD_WIDTH-1:0] y_in,
   input  logic                         first_vertex,
   input  cfg_type                      cfg,
   input  logic signed [BW-1:0]         sin_val,
   input  logic signed [BW-1:0]         cos_val,
   input  queue_status_type             q_status,
   output logic                         q_push,
   output logic [ENTRY_W-1:0]           q_wdata
);

   logic signed [COORD_WIDTH-1:0] pivot_x_ff, pivot_x_in;
   logic signed [COORD_WIDTH-1:0] pivot_y_ff, pivot_y_in;

   logic signed [AW-1:0] xe, ye, pxe, pye, dx, dy;
   logic signed [BW-1:0] one_b, fx, fy, fx_c, fy_c;
   logic signed [AW-1:0] ax0, ax1, ay0, ay1;
   logic signed [BW-1:0] bx0, bx1, by0, by1;
   logic                 rot;

   assign in_ready = !q_status.full;
   assign q_push   = in_valid && in_ready;

   always_comb begin
      xe    = AW'(x_in);
      ye    = AW'(y_in);
      pxe   = AW'(pivot_x_ff);
      pye   = AW'(pivot_y_ff);
      dx    = xe - AW'(CENTER_X);
      dy    = AW'(CENTER_Y) - ye;
      one_b = BW'(1);
      fx    = BW'(cfg.scale_x);
      fy    = BW'(cfg.scale_y);
      fx_c  = one_b - fx;
      fy_c  = one_b - fy;

      // Default: vertex passes through as x*1 + 0.
      rot = 1'b0;
      ax0 = xe;
      bx0 = one_b;
      ax1 = '0;
      bx1 = '0;
      ay0 = ye;
      by0 = one_b;
      ay1 = '0;
      by1 = '0;

      unique case (cfg.mode)
         MODE_TRANSLATE: begin
            ax0 = xe + AW'(cfg.shift_x);
            ay0 = ye - AW'(cfg.shift_y);
         end
         MODE_ROTATE: begin
            rot = 1'b1;
            ax0 = dx;
            bx0 = cos_val;
            ax1 = dy;
            bx1 = -sin_val;
            ay0 = dy;
            by0 = -cos_val;
            ay1 = dx;
            by1 = -sin_val;
         end
         MODE_SCALE: begin
            // The pivot vertex itself comes back unchanged.
            if (!first_vertex) begin
               bx0 = fx;
               ax1 = pxe;
               bx1 = fx_c;
               by0 = fy;
               ay1 = pye;
               by1 = fy_c;
            end
         end
         MODE_REFLECT_Y: begin
            ax0 = AW'(2 * CENTER_X) - xe;
         end
         MODE_REFLECT_X: begin
            ay0 = AW'(2 * CENTER_Y) - ye;
         end
         default: begin
         end
      endcase

      pivot_x_in = pivot_x_ff;
      pivot_y_in = pivot_y_ff;
      if (q_push && first_vertex) begin
         pivot_x_in = x_in;
         pivot_y_in = y_in;
      end
   end

   assign q_wdata = {by1, by0, bx1, bx0, ay1, ay0, ax1, ax0, rot};

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
      end else begin
         pivot_x_ff <= pivot_x_in;
         pivot_y_ff <= pivot_y_in;
      end
   end

endmodule

@@ rtl/pt2d_back.sv @@
module pt2d_back
   import pt2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEFAULT,
   localparam int AW = COORD_WIDTH + 2,
   localparam int BW = TRIG_FRACTION_BITS + 2,
   localparam int ENTRY_W = 1 + 4 * AW + 4 * BW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ENTRY_W-1:0]            q_rdata,
   input  queue_status_type              q_status,
   output logic                          q_pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] x_out,
   output logic signed [COORD_WIDTH-1:0] y_out,
   output logic                          saturated
);

   localparam int PW = AW + BW;
   localparam int SW = PW + 2;
   localparam int F  = TRIG_FRACTION_BITS;

   localparam logic signed [SW-1:0] K_X  = SW'(CENTER_X) << F;
   localparam logic signed [SW-1:0] K_Y  = SW'(CENTER_Y) << F;
   localparam logic signed [SW-1:0] BIAS = {{(SW-F){1'b0}}, {F{1'b1}}};
   localparam logic signed [SW-1:0] HI   = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] LO   = {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   logic signed [AW-1:0] ax0, ax1, ay0, ay1;
   logic signed [BW-1:0] bx0, bx1, by0, by1;
   logic                 rot;

   logic                 advance;
   logic                 s1_valid_ff, s1_rot_ff;
   logic signed [PW-1:0] px0_ff, px1_ff, py0_ff, py1_ff;
   logic                 s2_valid_ff, s2_rot_ff;
   logic signed [SW-1:0] sum_x_ff, sum_y_ff, sum_x_in, sum_y_in;
   logic                 out_valid_ff;
   logic signed [COORD_WIDTH-1:0] x_out_ff, y_out_ff, x_out_in, y_out_in;
   logic                 sat_ff, sat_in;
   logic signed [SW-1:0] qx, qy;

   assign {by1, by0, bx1, bx0, ay1, ay0, ax1, ax0, rot} = q_rdata;

   // The whole pipe moves together unless the output register is held.
   assign advance = !out_valid_ff || out_ready;
   assign q_pop   = advance && !q_status.empty;

   function automatic logic signed [SW-1:0] trunc_frac(input logic signed [SW-1:0] v,
                                                      input logic shift_en);
      logic signed [SW-1:0] b;
      b = v;
      if (shift_en) begin
         if (v[SW-1]) begin
            b = v + BIAS;
         end
         b = b >>> F;
      end
      return b;
   endfunction

   always_comb begin
      sum_x_in = (s1_rot_ff ? K_X : SW'(0)) + SW'(px0_ff) + SW'(px1_ff);
      sum_y_in = (s1_rot_ff ? K_Y : SW'(0)) + SW'(py0_ff) + SW'(py1_ff);

      qx = trunc_frac(sum_x_ff, s2_rot_ff);
      qy = trunc_frac(sum_y_ff, s2_rot_ff);

      sat_in   = 1'b0;
      x_out_in = qx[COORD_WIDTH-1:0];
      y_out_in = qy[COORD_WIDTH-1:0];
      if (qx > HI) begin
         x_out_in = HI[COORD_WIDTH-1:0];
         sat_in   = 1'b1;
      end else if (qx < LO) begin
         x_out_in = LO[COORD_WIDTH-1:0];
         sat_in   = 1'b1;
      end
      if (qy > HI) begin
         y_out_in = HI[COORD_WIDTH-1:0];
         sat_in   = 1'b1;
      end else if (qy < LO) begin
         y_out_in = LO[COORD_WIDTH-1:0];
         sat_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !q_status.empty;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rot_ff <= rot;
         px0_ff    <= PW'(ax0) * PW'(bx0);
         px1_ff    <= PW'(ax1) * PW'(bx1);
         py0_ff    <= PW'(ay0) * PW'(by0);
         py1_ff    <= PW'(ay1) * PW'(by1);
         s2_rot_ff <= s1_rot_ff;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         x_out_ff  <= x_out_in;
         y_out_ff  <= y_out_in;
         sat_ff    <= sat_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign x_out     = x_out_ff;
   assign y_out     = y_out_ff;
   assign saturated = sat_ff;

endmodule

@@ rtl/point_transform_2d_core.sv @@
// Path: a request passes the queue, then the product, sum and output registers.
// Throughput: one vertex per cycle while the output register is not held, set by
// the fully pipelined multiply, sum and clamp stages of the back end, which move together.
// Reset (synchronous, active high) empties the queue and the pipeline, sets mode 0,
// zero shifts, angle 0 (sine 0, cosine 1) and unit scales, and clears the pivot.
module point_transform_2d_core
   import pt2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEFAULT,
   localparam int DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // x_in, y_in, zero padding
   input  logic                  req_tuser,   // first_vertex
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // x_out, y_out, zero padding
   output logic                  rsp_tuser,   // saturated
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = COORD_WIDTH + 2;
   localparam int BW = TRIG_FRACTION_BITS + 2;
   localparam int ENTRY_W = 1 + 4 * AW + 4 * BW;

   // The angle register is only ever seen through its sine and cosine, so a
   // write of the angle looks both up at once and stores them.
   logic signed [BW-1:0] sin_rom [ANGLE_CODES];
   logic signed [BW-1:0] cos_rom [ANGLE_CODES];

   for (genvar g = 0; g < ANGLE_CODES; g++) begin : g_trig_rom
      localparam logic signed [BW-1:0] SIN_G = BW'(trig_entry(g, TRIG_FRACTION_BITS, 1'b1));
      localparam logic signed [BW-1:0] COS_G = BW'(trig_entry(g, TRIG_FRACTION_BITS, 1'b0));
      assign sin_rom[g] = SIN_G;
      assign cos_rom[g] = COS_G;
   end

   cfg_type              cfg_ff, cfg_in;
   logic signed [BW-1:0] sin_ff, sin_in;
   logic signed [BW-1:0] cos_ff, cos_in;

   always_comb begin
      cfg_in = cfg_ff;
      sin_in = sin_ff;
      cos_in = cos_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_MODE:    cfg_in.mode    = csr_wdata[2:0];
            REG_SHIFT_X: cfg_in.shift_x = csr_wdata[12:0];
            REG_SHIFT_Y: cfg_in.shift_y = csr_wdata[12:0];
            REG_ANGLE: begin
               sin_in = sin_rom[csr_wdata[8:0]];
               cos_in = cos_rom[csr_wdata[8:0]];
            end
            REG_SCALE_X: cfg_in.scale_x = csr_wdata[6:0];
            REG_SCALE_Y: cfg_in.scale_y = csr_wdata[6:0];
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_TRANSLATE;
         cfg_ff.shift_x <= '0;
         cfg_ff.shift_y <= '0;
         cfg_ff.scale_x <= 7'sd1;
         cfg_ff.scale_y <= 7'sd1;
         sin_ff         <= '0;
         cos_ff         <= BW'(1) << TRIG_FRACTION_BITS;
      end else begin
         cfg_ff <= cfg_in;
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   // Front end: accepts a vertex, keeps the pivot and turns the mode into
   // multiplier operands. The queue lets it keep taking transactions while
   // the back end waits on the response side.
   queue_status_type   q_status;
   logic               q_push;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_wdata;
   logic [ENTRY_W-1:0] q_rdata;

   logic signed [COORD_WIDTH-1:0] x_out;
   logic signed [COORD_WIDTH-1:0] y_out;

   pt2d_front #(
      .COORD_WIDTH        (COORD_WIDTH),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .x_in         (req_tdata[COORD_WIDTH-1:0]),
      .y_in         (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .first_vertex (req_tuser),
      .cfg          (cfg_ff),
      .sin_val      (sin_ff),
      .cos_val      (cos_ff),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_wdata      (q_wdata)
   );

   pt2d_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // Back end: products, sums, then truncation toward zero and clamping into
   // the response register.
   pt2d_back #(
      .COORD_WIDTH        (COORD_WIDTH),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rdata   (q_rdata),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .x_out     (x_out),
      .y_out     (y_out),
      .saturated (rsp_tuser)
   );

   assign rsp_tdata = DATA_W'({y_out, x_out});

endmodule

@@ tb/sv/point_transform_2d_core_test.sv @@
`timescale 1ns / 100ps

module point_transform_2d_core_test;
   import pt2d_pkg::*;

   localparam int COORD_W = COORD_WIDTH_DEFAULT;
   localparam int TRIG_F = TRIG_FRACTION_BITS_DEFAULT;
   localparam int DATA_W = ((2 * COORD_W + 7) / 8) * 8;

   // The series for sine and cosine runs in Q33 and is rounded half away from zero to TRIG_F bits.
   localparam int SERIES_Q = 33;
   localparam int SERIES_LEN = 60;
   localparam longint ONE_TRIG = longint'(1) << TRIG_F;

   // Mode codes above reflection have no name in the package; they pass a vertex through.
   localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

   // One vertex as it travels on the request channel.
   typedef struct packed {
      logic               first;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } vertex_in_type;

   // One transformed vertex as it comes back on the response channel.
   typedef struct packed {
      logic               sat;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } vertex_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;   // x_in, y_in, zero padding
   logic                  req_tuser = 1'b0; // first_vertex
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;        // x_out, y_out, zero padding
   logic                  rsp_tuser;        // saturated
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   point_transform_2d_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Vertices waiting to be offered, and transformed vertices still owed by the block.
   vertex_in_type  vertex_queue[$];
   vertex_out_type expected_vertices[$];

   // Sine and cosine of every 9-bit angle code, in TRIG_F fraction bits.
   longint sine_q [0:ANGLE_CODES-1];
   longint cosine_q [0:ANGLE_CODES-1];

   // Our own copy of the configuration registers and of the scaling pivot.
   logic [2:0]         cfg_mode;
   logic signed [12:0] cfg_shift_x;
   logic signed [12:0] cfg_shift_y;
   logic [8:0]         cfg_angle;
   logic signed [6:0]  cfg_scale_x;
   logic signed [6:0]  cfg_scale_y;
   longint             pivot_x;
   longint             pivot_y;

   int mismatch_count = 0;

   // Handshake history seen at the last rising edge, used by the driver and the receiver.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Idle settings for the current phase. Each side draws a wait from 0 to its maximum.
   int req_idle_max = 0;
   int rsp_idle_max = 0;
   int req_gap = 0;
   int rsp_wait = 0;
   int rsp_draw;

   // The long receiver hold-off is requested by bumping the token; the receiver counts it.
   int hold_token = 0;
   int hold_seen = 0;
   int hold_length = 0;
   int hold_left = 0;

   longint         vin_x;
   longint         vin_y;
   vertex_out_type want;

   // Rounds half away from zero from Q33 down to TRIG_F fraction bits.
   function automatic longint round_series(input longint v);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (SERIES_Q - TRIG_F - 1))) >>> (SERIES_Q - TRIG_F);
      return (v < 0) ? -mag : mag;
   endfunction

   // Drops TRIG_F fraction bits, rounding toward zero.
   function automatic longint trunc_fraction(input longint v);
      if (v < 0)
         return -((-v) >>> TRIG_F);
      return v >>> TRIG_F;
   endfunction

   // Clamps to the signed coordinate range; the top bit of the result says it clamped.
   function automatic logic [COORD_W:0] clamp_coord(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi)
         return {1'b1, COORD_W'(hi)};
      if (v < lo)
         return {1'b1, COORD_W'(lo)};
      return {1'b0, COORD_W'(v)};
   endfunction

   // Transforms one vertex under the current configuration. The pivot must already hold
   // this vertex if it is the first of its polygon.
   function automatic vertex_out_type transform_vertex(input longint x, input longint y,
                                                       input logic first);
      longint            rx;
      longint            ry;
      longint            dx;
      longint            dy;
      longint            sn;
      longint            cs;
      longint            fx;
      longint            fy;
      logic [COORD_W:0]  cx;
      logic [COORD_W:0]  cy;
      vertex_out_type    res;
      rx = x;
      ry = y;
      unique case (cfg_mode)
         MODE_TRANSLATE: begin
            // Screen y points down, so an upward shift is subtracted.
            rx = x + longint'(cfg_shift_x);
            ry = y - longint'(cfg_shift_y);
         end
         MODE_ROTATE: begin
            sn = sine_q[cfg_angle];
            cs = cosine_q[cfg_angle];
            dx = x - longint'(CENTER_X);
            dy = longint'(CENTER_Y) - y;
            rx = trunc_fraction(longint'(CENTER_X) * ONE_TRIG + dx * cs - dy * sn);
            ry = trunc_fraction(longint'(CENTER_Y) * ONE_TRIG - dy * cs - dx * sn);
         end
         MODE_SCALE: begin
            // The first vertex is the pivot itself and comes back unchanged.
            if (!first) begin
               fx = longint'(cfg_scale_x);
               fy = longint'(cfg_scale_y);
               rx = x * fx + pivot_x * (1 - fx);
               ry = y * fy + pivot_y * (1 - fy);
            end
         end
         MODE_REFLECT_Y: rx = 2 * longint'(CENTER_X) - x;
         MODE_REFLECT_X: ry = 2 * longint'(CENTER_Y) - y;
         default: ;
      endcase
      cx = clamp_coord(rx);
      cy = clamp_coord(ry);
      res.x = cx[COORD_W-1:0];
      res.y = cy[COORD_W-1:0];
      res.sat = cx[COORD_W] | cy[COORD_W];
      return res;
   endfunction

   // Monitor: everything is sampled at the rising edge, where a transaction completes.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         cfg_mode = MODE_TRANSLATE;
         cfg_shift_x = '0;
         cfg_shift_y = '0;
         cfg_angle = '0;
         cfg_scale_x = 7'sd1;
         cfg_scale_y = 7'sd1;
         pivot_x = 0;
         pivot_y = 0;
         expected_vertices.delete();
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (csr_we) begin
            unique case (csr_addr)
               REG_MODE:    cfg_mode = csr_wdata[2:0];
               REG_SHIFT_X: cfg_shift_x = csr_wdata[12:0];
               REG_SHIFT_Y: cfg_shift_y = csr_wdata[12:0];
               REG_ANGLE:   cfg_angle = csr_wdata[8:0];
               REG_SCALE_X: cfg_scale_x = csr_wdata[6:0];
               REG_SCALE_Y: cfg_scale_y = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            vin_x = longint'($signed(req_tdata[COORD_W-1:0]));
            vin_y = longint'($signed(req_tdata[2*COORD_W-1:COORD_W]));
            // The pivot is taken from every first vertex, whatever the mode.
            if (req_tuser) begin
               pivot_x = vin_x;
               pivot_y = vin_y;
            end
            expected_vertices.push_back(transform_vertex(vin_x, vin_y, req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_vertices.size() == 0) begin
               $error("unexpected response transaction: x_out %0d, y_out %0d",
                      $signed(rsp_tdata[COORD_W-1:0]),
                      $signed(rsp_tdata[2*COORD_W-1:COORD_W]));
               mismatch_count++;
            end else begin
               want = expected_vertices.pop_front();
               if (rsp_tdata[COORD_W-1:0] !== want.x) begin
                  $error("x_out: expected %0d, got %0d", $signed(want.x),
                         $signed(rsp_tdata[COORD_W-1:0]));
                  mismatch_count++;
               end
               if (rsp_tdata[2*COORD_W-1:COORD_W] !== want.y) begin
                  $error("y_out: expected %0d, got %0d", $signed(want.y),
                         $signed(rsp_tdata[2*COORD_W-1:COORD_W]));
                  mismatch_count++;
               end
               if (rsp_tuser !== want.sat) begin
                  $error("saturated: expected %0d, got %0d", want.sat, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Driver: offers the next queued vertex once the current transaction is done and the
   // drawn gap has run out. The valid is assigned once per falling edge at most.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (vertex_queue.size() != 0) begin
            req_tdata <= DATA_W'({vertex_queue[0].y, vertex_queue[0].x});
            req_tuser <= vertex_queue[0].first;
            req_tvalid <= 1'b1;
            req_gap <= $urandom_range(0, req_idle_max);
            void'(vertex_queue.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: after each response transaction it draws how long to hold ready low.
   // A requested hold-off overrides that and keeps ready low for the requested hold length.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= hold_length;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_taken) begin
         rsp_draw = $urandom_range(0, rsp_idle_max);
         rsp_wait <= rsp_draw;
         rsp_tready <= (rsp_draw == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Writes one register. The enable drops again before the task returns, so calls can
   // follow each other directly.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_addr <= addr;
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_vertex(input int x, input int y, input logic first);
      vertex_in_type v;
      v.x = 16'(x);
      v.y = 16'(y);
      v.first = first;
      vertex_queue.push_back(v);
   endtask

   // Waits until every queued vertex has been accepted and every response has arrived.
   // The state is looked at on rising edges, where the driver never changes it.
   task automatic drain_results();
      @(posedge clock);
      while (vertex_queue.size() != 0 || req_tvalid || expected_vertices.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Run limit: far beyond the slowest correct run with the largest gaps on both sides.
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      longint unsigned arg;
      longint unsigned term;
      longint          s_acc;
      longint          c_acc;
      int              phase;
      int              count;
      int              corners;
      int              mode_sel;
      int              shx;
      int              shy;
      int              ang;
      int              scx;
      int              scy;
      int              sides;
      logic            noisy;

      // Angle table from the Maclaurin series of d * 0.01744 rad, truncating each step.
      for (int d = 0; d < ANGLE_CODES; d++) begin
         arg = longint'(d) * 1744;
         term = longint'(1) << SERIES_Q;
         s_acc = 0;
         c_acc = longint'(term);
         for (longint unsigned m = 1; m <= SERIES_LEN; m++) begin
            term = term * arg / 100000 / m;
            unique case (m % 4)
               1: s_acc = s_acc + longint'(term);
               2: c_acc = c_acc - longint'(term);
               3: s_acc = s_acc - longint'(term);
               default: c_acc = c_acc + longint'(term);
            endcase
         end
         sine_q[d] = round_series(s_acc);
         cosine_q[d] = round_series(c_acc);
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Scaling before any first vertex has been seen uses the reset pivot at the origin.
      write_reg(REG_MODE, CSR_DATA_W'(MODE_SCALE));
      write_reg(REG_SCALE_X, CSR_DATA_W'(3));
      write_reg(REG_SCALE_Y, CSR_DATA_W'(-2));
      queue_vertex(100, -50, 1'b0);
      drain_results();

      // Translation with the reset shifts of zero, including coordinate extremes.
      write_reg(REG_MODE, CSR_DATA_W'(MODE_TRANSLATE));
      queue_vertex(32767, -32768, 1'b0);
      queue_vertex(-32768, 32767, 1'b0);
      queue_vertex(0, 0, 1'b0);
      queue_vertex(100, 50, 1'b1);
      drain_results();

      // Extreme shifts push both coordinates of some vertices out of range.
      write_reg(REG_SHIFT_X, CSR_DATA_W'(4095));
      write_reg(REG_SHIFT_Y, CSR_DATA_W'(-4096));
      queue_vertex(32767, 32767, 1'b0);
      queue_vertex(-32768, -32768, 1'b0);
      drain_results();
      write_reg(REG_SHIFT_X, CSR_DATA_W'(-4096));
      write_reg(REG_SHIFT_Y, CSR_DATA_W'(4095));
      queue_vertex(-32768, -32768, 1'b0);
      drain_results();

      // Rotation: angle zero from reset, then quarter and half turns, the last whole
      // degree and the largest code beyond 359, which is not wrapped.
      write_reg(REG_MODE, CSR_DATA_W'(MODE_ROTATE));
      queue_vertex(320, 240, 1'b0);
      queue_vertex(-32768, 32767, 1'b0);
      drain_results();
      write_reg(REG_ANGLE, CSR_DATA_W'(90));
      queue_vertex(330, 240, 1'b0);
      drain_results();
      write_reg(REG_ANGLE, CSR_DATA_W'(180));
      queue_vertex(32767, -32768, 1'b0);
      drain_results();
      write_reg(REG_ANGLE, CSR_DATA_W'(359));
      queue_vertex(400, 100, 1'b0);
      drain_results();
      write_reg(REG_ANGLE, CSR_DATA_W'(511));
      queue_vertex(0, 0, 1'b0);
      drain_results();

      // Scaling at the extreme factors: the first vertex returns unchanged.
      write_reg(REG_MODE, CSR_DATA_W'(MODE_SCALE));
      write_reg(REG_SCALE_X, CSR_DATA_W'(63));
      write_reg(REG_SCALE_Y, CSR_DATA_W'(-64));
      queue_vertex(10, 20, 1'b1);
      queue_vertex(1000, -1000, 1'b0);
      queue_vertex(11, 21, 1'b0);
      drain_results();

      write_reg(REG_MODE, CSR_DATA_W'(MODE_REFLECT_Y));
      queue_vertex(32767, 5, 1'b0);
      queue_vertex(-32768, 0, 1'b0);
      drain_results();
      write_reg(REG_MODE, CSR_DATA_W'(MODE_REFLECT_X));
      queue_vertex(0, -32768, 1'b0);
      drain_results();

      // Unused mode codes pass the vertex through.
      for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
         write_reg(REG_MODE, CSR_DATA_W'(m));
         queue_vertex((m == MODE_UNUSED_FIRST) ? 32767 : -1, -32768, 1'b1);
         drain_results();
      end

      // Random phases: a fresh configuration each, then polygons of random vertices.
      for (phase = 0; phase < 16; phase++) begin
         if (phase < 10)
            mode_sel = phase % 5;
         else if ($urandom_range(0, 7) == 0)
            mode_sel = $urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST);
         else
            mode_sel = $urandom_range(MODE_TRANSLATE, MODE_REFLECT_X);
         if (phase % 4 == 0) begin
            // Every fourth phase uses the extreme register values.
            shx = $urandom_range(0, 1) ? 4095 : -4096;
            shy = $urandom_range(0, 1) ? 4095 : -4096;
            case ($urandom_range(0, 2))
               0: ang = 0;
               1: ang = 359;
               default: ang = 511;
            endcase
            scx = $urandom_range(0, 1) ? 63 : -64;
            scy = $urandom_range(0, 1) ? 63 : -64;
         end else begin
            shx = int'($urandom_range(0, 8191)) - 4096;
            shy = int'($urandom_range(0, 8191)) - 4096;
            ang = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511)
                                              : $urandom_range(0, 359);
            scx = int'($urandom_range(0, 127)) - 64;
            scy = int'($urandom_range(0, 127)) - 64;
         end
         write_reg(REG_MODE, CSR_DATA_W'(mode_sel));
         write_reg(REG_SHIFT_X, CSR_DATA_W'(shx));
         write_reg(REG_SHIFT_Y, CSR_DATA_W'(shy));
         write_reg(REG_ANGLE, CSR_DATA_W'(ang));
         write_reg(REG_SCALE_X, CSR_DATA_W'(scx));
         write_reg(REG_SCALE_Y, CSR_DATA_W'(scy));

         case ($urandom_range(0, 2))
            0: req_idle_max = 0;
            1: req_idle_max = 4;
            default: req_idle_max = 16;
         endcase
         case ($urandom_range(0, 2))
            0: rsp_idle_max = 0;
            1: rsp_idle_max = 4;
            default: rsp_idle_max = 16;
         endcase

         // In one phase the receiver stops for a long time while the sender keeps
         // offering back to back, so the block fills up and stalls its input.
         if (phase == 5) begin
            req_idle_max = 0;
            hold_length = 300;
            hold_token++;
         end

         // Mostly well-formed polygons on screen; some vertices are noise over the whole
         // coordinate range with a random first-vertex flag.
         count = 0;
         while (count < 50) begin
            sides = $urandom_range(3, 8);
            for (corners = 0; corners < sides; corners++) begin
               noisy = ($urandom_range(0, 7) == 0);
               if (noisy)
                  queue_vertex(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                               1'($urandom_range(0, 1)));
               else
                  queue_vertex($urandom_range(0, 639), $urandom_range(0, 479),
                               (corners == 0));
               count++;
            end
         end
         drain_results();
      end

      repeat (16) @(negedge clock);
      if (expected_vertices.size() != 0) begin
         $error("%0d response transactions never arrived", expected_vertices.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
